// ===== hdl/bpwn_pkg.sv =====
// Package for the band power window normalizer.
// Holds request types, register indexes, sequencer states and sizing constants.
// No dependencies.
package bpwn_pkg;

	localparam int WINDOW_DEPTH = 32;
	localparam int BIN_COUNT    = 64;
	localparam int HEAD_W       = $clog2(WINDOW_DEPTH);
	localparam int COUNT_W      = HEAD_W + 1;
	localparam int SUM_W        = 16 + HEAD_W;
	localparam int ACC_W        = 38;
	localparam int X_W          = ACC_W + 1;
	localparam int DIV_NW       = 24;
	localparam int DIV_DW       = 16;
	localparam int DIV_CW       = $clog2(DIV_NW + 1);

	localparam logic [31:0] DB_PER_OCTAVE = 32'd101008905;

	typedef enum logic [1:0] {
		CFG_BAND_LOW   = 2'd0,
		CFG_BAND_HIGH  = 2'd1,
		CFG_WINDOW_LEN = 2'd2,
		CFG_NONE       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] bin_power;
		logic [5:0]  bin_index;
		logic        last_bin;
		logic        last_vertex;
	} in_req_t;

	typedef struct packed {
		logic [8:0]  level;
		logic [15:0] power_db;
		logic        frame_end;
	} out_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MMIN_GO,
		ST_MMIN_WT,
		ST_MMAX_GO,
		ST_MMAX_WT,
		ST_NORM,
		ST_SQ_MUL,
		ST_SQ_UPD,
		ST_DB_MUL,
		ST_DB_RND,
		ST_LVL_GO,
		ST_LVL_WT,
		ST_DROP,
		ST_PUSH,
		ST_DONE
	} st_t;

endpackage

// ===== hdl/bpwn_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bpwn_pkg for operand widths.
module bpwn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bpwn_pkg::DIV_NW-1:0] num,
	input  logic [bpwn_pkg::DIV_DW-1:0] den,
	output logic                       busy,
	output logic                       done,
	output logic [bpwn_pkg::DIV_NW-1:0] quo
);
	import bpwn_pkg::*;

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] nq_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   sh;
	logic              fits;

	assign sh   = {rem_q, nq_q[DIV_NW-1]};
	assign fits = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nq_q  <= num;
		end else if (busy_q) begin
			// remainder stays below den, so the low bits hold it
			rem_q <= fits ? DIV_DW'(sh - {1'b0, den_q}) : sh[DIV_DW-1:0];
			nq_q  <= {nq_q[DIV_NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = nq_q;

endmodule

// ===== hdl/band_power_window_normalizer.sv =====
// Top level of the band power window normalizer: sequencer, shared multiplier,
// history windows. Depends on bpwn_pkg and bpwn_div.
//
// Usage: bins stream in on in_valid/in_ready/in_data. A bin whose index lies in
// [band_low, band_high) adds to the band sum (saturating at 2^38-1). Bins
// without last_bin are taken one per cycle and give no result. A request with
// last_bin starts the vertex sequence and in_ready stays low until its result
// has been loaded into the output register. Sequence: two mean divisions on the
// shared serial divider (first vertex of a frame, history not empty), top-bit
// search, log2 squaring and dB scaling on the shared 32x32 multiplier, a level
// division when the level needs a ratio, then the history drop and push on a
// frame's last vertex. The result sits in out_data with out_valid until
// out_ready; while it waits further bins without last_bin are still taken, and
// a new vertex sequence can run, stalling only at its final load. Configuration
// writes (cfg_wr_en) must come while idle; the block does not enforce this.
// Each write, unless to CFG_NONE, clears the history windows and latched means.
// Reset loads band [8, 12), window length 32, empty history.
module band_power_window_normalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpwn_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bpwn_pkg::out_req_t out_data,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import bpwn_pkg::*;

	st_t state_q, state_d;

	logic [5:0]         band_low_q;
	logic [6:0]         band_high_q;
	logic [5:0]         window_len_q;
	logic [15:0]        min_hist_q [WINDOW_DEPTH];
	logic [15:0]        max_hist_q [WINDOW_DEPTH];
	logic [HEAD_W-1:0]  head_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_min_q, sum_max_q;
	logic [15:0]        mean_min_q, mean_max_q;
	logic [15:0]        fmin_q, fmax_q;
	logic [ACC_W-1:0]   acc_q;
	logic               started_q;
	logic [X_W-1:0]     x_q;
	logic [5:0]         e_q;
	logic [31:0]        m_q;
	logic [15:0]        frac_q;
	logic [3:0]         iter_q;
	logic [63:0]        prod_q;
	logic [15:0]        db_q;
	logic [8:0]         level_q;
	logic               lastv_q;
	out_req_t           out_q;
	logic               out_valid_q;

	logic               accept;
	logic               in_band;
	logic [ACC_W:0]     acc_sum;
	logic [ACC_W-1:0]   acc_sat;
	logic [31:0]        mul_a, mul_b;
	logic [20:0]        l_val;
	logic [32:0]        db_round;
	logic [15:0]        db_next;
	logic [16:0]        diff, scale;
	logic               diff_pos, scale_pos;
	logic [5:0]         eff_len;
	logic [COUNT_W-1:0] cap;
	logic               must_drop;
	logic [HEAD_W-1:0]  slot;
	logic               div_start, div_busy, div_done;
	logic [DIV_NW-1:0]  div_num, div_quo;
	logic [DIV_DW-1:0]  div_den;
	logic               out_free;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign in_band = ({1'b0, in_data.bin_index} < 7'(BIN_COUNT))
		&& (in_data.bin_index >= band_low_q)
		&& ({1'b0, in_data.bin_index} < band_high_q);
	assign acc_sum = {1'b0, acc_q} + (ACC_W+1)'(in_data.bin_power);
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	assign l_val    = {5'(e_q - 6'd8), frac_q};
	assign db_round = 33'(prod_q[63:32]) + 33'(prod_q[31]);
	assign db_next  = (db_round > 33'h0FFFF) ? 16'hFFFF : db_round[15:0];

	assign diff      = {1'b0, db_q} - {1'b0, mean_min_q};
	assign scale     = {1'b0, mean_max_q} - {1'b0, mean_min_q};
	assign diff_pos  = !diff[16] && (diff != '0);
	assign scale_pos = !scale[16] && (scale != '0);

	assign eff_len   = (window_len_q < 6'd2) ? 6'd2 :
		(window_len_q > 6'(WINDOW_DEPTH)) ? 6'(WINDOW_DEPTH) : window_len_q;
	assign cap       = COUNT_W'(eff_len - 6'd1);
	assign must_drop = (count_q >= cap) && (count_q != '0);
	assign slot      = head_q + count_q[HEAD_W-1:0];

	// shared multiplier operands
	always_comb begin
		if (state_q == ST_SQ_MUL) begin
			mul_a = m_q;
			mul_b = m_q;
		end else begin
			mul_a = 32'(l_val);
			mul_b = DB_PER_OCTAVE;
		end
	end

	// shared divider requests
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_MMIN_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(sum_min_q);
				div_den   = DIV_DW'(count_q);
			end
			ST_MMAX_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(sum_max_q);
				div_den   = DIV_DW'(count_q);
			end
			ST_LVL_GO: begin
				div_start = scale_pos && diff_pos;
				div_num   = {diff[15:0], 8'd0};
				div_den   = scale[15:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept && in_data.last_bin) begin
					if (!started_q && count_q != '0) state_d = ST_MMIN_GO;
					else state_d = ST_NORM;
				end
			ST_MMIN_GO: state_d = ST_MMIN_WT;
			ST_MMIN_WT: if (div_done) state_d = ST_MMAX_GO;
			ST_MMAX_GO: state_d = ST_MMAX_WT;
			ST_MMAX_WT: if (div_done) state_d = ST_NORM;
			ST_NORM:    if (x_q[X_W-1]) state_d = ST_SQ_MUL;
			ST_SQ_MUL:  state_d = ST_SQ_UPD;
			ST_SQ_UPD:  state_d = (iter_q == 4'd15) ? ST_DB_MUL : ST_SQ_MUL;
			ST_DB_MUL:  state_d = ST_DB_RND;
			ST_DB_RND:  state_d = ST_LVL_GO;
			ST_LVL_GO: begin
				if (scale_pos && diff_pos) state_d = ST_LVL_WT;
				else state_d = lastv_q ? ST_DROP : ST_DONE;
			end
			ST_LVL_WT:  if (div_done) state_d = lastv_q ? ST_DROP : ST_DONE;
			ST_DROP:    if (!must_drop) state_d = ST_PUSH;
			ST_PUSH:    state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_low_q   <= 6'd8;
			band_high_q  <= 7'd12;
			window_len_q <= 6'd32;
			head_q       <= '0;
			count_q      <= '0;
			sum_min_q    <= '0;
			sum_max_q    <= '0;
			mean_min_q   <= '0;
			mean_max_q   <= '0;
			fmin_q       <= 16'hFFFF;
			fmax_q       <= '0;
			acc_q        <= '0;
			started_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:
					if (accept) begin
						if (in_data.last_bin) begin
							acc_q <= '0;
							if (!started_q && count_q == '0) begin
								mean_min_q <= '0;
								mean_max_q <= '0;
							end
							started_q <= 1'b1;
						end else if (in_band) begin
							acc_q <= acc_sat;
						end
					end
				ST_MMIN_WT: if (div_done) mean_min_q <= div_quo[15:0];
				ST_MMAX_WT: if (div_done) mean_max_q <= div_quo[15:0];
				ST_DB_RND: begin
					if (db_next > fmax_q) fmax_q <= db_next;
					if (db_next < fmin_q) fmin_q <= db_next;
				end
				ST_DROP:
					if (must_drop) begin
						sum_min_q <= sum_min_q - SUM_W'(min_hist_q[head_q]);
						sum_max_q <= sum_max_q - SUM_W'(max_hist_q[head_q]);
						head_q    <= head_q + 1'b1;
						count_q   <= count_q - 1'b1;
					end
				ST_PUSH: begin
					sum_min_q <= sum_min_q + SUM_W'(fmin_q);
					sum_max_q <= sum_max_q + SUM_W'(fmax_q);
					count_q   <= count_q + 1'b1;
					fmin_q    <= 16'hFFFF;
					fmax_q    <= '0;
					started_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (cfg_wr_en) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_BAND_LOW:   band_low_q   <= cfg_data[5:0];
					CFG_BAND_HIGH:  band_high_q  <= cfg_data;
					CFG_WINDOW_LEN: window_len_q <= cfg_data[5:0];
					default: begin
					end
				endcase
				if (cfg_idx_t'(cfg_index) != CFG_NONE) begin
					head_q     <= '0;
					count_q    <= '0;
					sum_min_q  <= '0;
					sum_max_q  <= '0;
					mean_min_q <= '0;
					mean_max_q <= '0;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE:
				if (accept && in_data.last_bin) begin
					x_q     <= (in_band ? {1'b0, acc_sat} : {1'b0, acc_q}) + X_W'(256);
					e_q     <= 6'(X_W - 1);
					lastv_q <= in_data.last_vertex;
					frac_q  <= '0;
					iter_q  <= '0;
				end
			ST_NORM:
				if (x_q[X_W-1]) m_q <= x_q[X_W-1:X_W-32];
				else begin
					x_q <= {x_q[X_W-2:0], 1'b0};
					e_q <= e_q - 1'b1;
				end
			ST_SQ_UPD: begin
				// m*m in Q2.62; top bit set means the square passed 2.0
				frac_q <= {frac_q[14:0], prod_q[63]};
				m_q    <= prod_q[63] ? prod_q[63:32] : prod_q[62:31];
				iter_q <= iter_q + 1'b1;
			end
			ST_DB_RND: db_q <= db_next;
			ST_LVL_GO:
				if (!scale_pos) level_q <= diff_pos ? 9'd256 : 9'd0;
				else if (!diff_pos) level_q <= 9'd0;
			ST_LVL_WT:
				if (div_done) begin
					if (div_quo < DIV_NW'(128)) level_q <= 9'd0;
					else if (div_quo > DIV_NW'(256)) level_q <= 9'd256;
					else level_q <= div_quo[8:0];
				end
			ST_PUSH: begin
				min_hist_q[slot] <= fmin_q;
				max_hist_q[slot] <= fmax_q;
			end
			ST_DONE:
				if (out_free) begin
					out_q.level     <= level_q;
					out_q.power_db  <= db_q;
					out_q.frame_end <= lastv_q;
				end
			default: begin
			end
		endcase
	end

	bpwn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(WINDOW_DEPTH - 1))
		else $error("history count beyond window");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_MMIN_WT || state_q == ST_MMAX_WT
			|| state_q == ST_LVL_WT))
		else $error("divider finished outside a wait state");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.level <= 9'd256)
		else $error("level above 1.0");

	a_vertex_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.last_bin |=> state_q != ST_IDLE)
		else $error("vertex request did not start the sequence");

endmodule

// ===== dv/bpwn_checker.sv =====
// Checker for band_power_window_normalizer: watches the bin, result and register channels,
// predicts each vertex result and compares it field by field. Depends on bpwn_pkg.
`timescale 1ns / 1ps
module bpwn_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  bpwn_pkg::in_req_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  bpwn_pkg::out_req_t out_data,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	output int                 fail_count,
	output int                 pending
);
	import bpwn_pkg::*;

	// predictor state
	int unsigned lo_bin, hi_bin, win_len;
	logic [15:0] min_win [WINDOW_DEPTH];
	logic [15:0] max_win [WINDOW_DEPTH];
	int unsigned head, cnt, min_total, max_total;
	logic [15:0] mean_lo, mean_hi, fr_min, fr_max;
	logic [63:0] band_sum;
	bit in_frame;

	out_req_t expected_levels[$];

	assign pending = expected_levels.size();

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic void clear_windows();
		head = 0;
		cnt = 0;
		min_total = 0;
		max_total = 0;
		mean_lo = 0;
		mean_hi = 0;
	endfunction

	function automatic logic [31:0] log2_q16(input logic [63:0] x);
		logic [63:0] m;
		int unsigned e;
		logic [31:0] frac;
		e = 0;
		frac = 0;
		while (e < 63 && (x >> e) > 1) e++;
		if (e <= 31) m = x << (31 - e);
		else m = x >> (e - 31);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (e << 16) | frac;
	endfunction

	function automatic logic [15:0] sum_to_db(input logic [63:0] s);
		logic [63:0] l, v;
		l = 64'(log2_q16(s + 256)) - (64'd8 << 16);
		v = (l * 64'(DB_PER_OCTAVE) + (64'd1 << 31)) >> 32;
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [8:0] level_of(input logic [15:0] db);
		int diff, span, q;
		diff = int'(db) - int'(mean_lo);
		span = int'(mean_hi) - int'(mean_lo);
		if (span <= 0) return (diff > 0) ? 9'd256 : 9'd0;
		if (diff <= 0) return 0;
		q = (diff * 256) / span;
		if (q < 128) return 0;
		return (q > 256) ? 9'd256 : 9'(q);
	endfunction

	function automatic void push_frame();
		int unsigned cap, slot;
		cap = (win_len < 2) ? 2 : ((win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : win_len);
		cap = cap - 1;
		while (cnt >= cap && cnt > 0) begin
			min_total -= min_win[head];
			max_total -= max_win[head];
			head = (head + 1) % WINDOW_DEPTH;
			cnt--;
		end
		slot = (head + cnt) % WINDOW_DEPTH;
		min_win[slot] = fr_min;
		max_win[slot] = fr_max;
		min_total += fr_min;
		max_total += fr_max;
		cnt++;
	endfunction

	function automatic void predict_bin(input in_req_t r);
		out_req_t res;
		logic [15:0] db;
		if (r.bin_index >= lo_bin && r.bin_index < hi_bin) begin
			band_sum = band_sum + r.bin_power;
			if (band_sum > ((64'd1 << ACC_W) - 1)) band_sum = (64'd1 << ACC_W) - 1;
		end
		if (!r.last_bin) return;
		if (!in_frame) begin
			mean_lo = (cnt != 0) ? 16'(min_total / cnt) : 16'd0;
			mean_hi = (cnt != 0) ? 16'(max_total / cnt) : 16'd0;
			in_frame = 1;
		end
		db = sum_to_db(band_sum);
		band_sum = 0;
		if (db > fr_max) fr_max = db;
		if (db < fr_min) fr_min = db;
		res.level = level_of(db);
		res.power_db = db;
		res.frame_end = r.last_vertex;
		expected_levels = {expected_levels, res};
		if (r.last_vertex) begin
			push_frame();
			fr_min = 16'hFFFF;
			fr_max = 0;
			in_frame = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_req_t want;
		if (!arst_n) begin
			lo_bin = 8;
			hi_bin = 12;
			win_len = 32;
			clear_windows();
			fr_min = 16'hFFFF;
			fr_max = 0;
			band_sum = 0;
			in_frame = 0;
			expected_levels.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BAND_LOW: begin
						lo_bin = cfg_data[5:0];
						clear_windows();
					end
					CFG_BAND_HIGH: begin
						hi_bin = cfg_data;
						clear_windows();
					end
					CFG_WINDOW_LEN: begin
						win_len = cfg_data[5:0];
						clear_windows();
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_bin(in_data);
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					report("unexpected result", out_data.power_db, 0);
				end else begin
					want = expected_levels.pop_front();
					if (out_data.level !== want.level)
						report("level", out_data.level, want.level);
					if (out_data.power_db !== want.power_db)
						report("power_db", out_data.power_db, want.power_db);
					if (out_data.frame_end !== want.frame_end)
						report("frame_end", out_data.frame_end, want.frame_end);
				end
			end
		end
	end

	initial fail_count = 0;
endmodule

// ===== dv/band_power_window_normalizer_tb.sv =====
// Testbench top for band_power_window_normalizer: clock, reset, bin stimulus,
// register phases and verdict. Depends on bpwn_pkg, the block and bpwn_checker.
`timescale 1ns / 1ps
module band_power_window_normalizer_tb;
	import bpwn_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_req_t in_data;
	out_req_t out_data;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	int fail_count, pending;

	int tx_idle_pct, rx_stall_pct;
	int hold_req, hold_left;
	int bins_sent;

	band_power_window_normalizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bpwn_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("band_power_window_normalizer verification failed");
		$finish;
	end

	// result side; a long hold is counted here
	initial begin
		out_ready = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_bin(input logic [31:0] pwr, input logic [5:0] idx,
			input logic lb, input logic lv);
		int gap;
		gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 10) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{bin_power: pwr, bin_index: idx, last_bin: lb, last_vertex: lv};
		do @(posedge clk); while (!in_ready);
		bins_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		// the history push is done before its result is loaded, so this wait only idles
		repeat (300) @(negedge clk);
	endtask

	task automatic write_regs(input logic [6:0] lo, input logic [6:0] hi, input logic [6:0] wl);
		cfg_wr_en <= 1;
		cfg_index <= CFG_BAND_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CFG_BAND_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= CFG_WINDOW_LEN;
		cfg_data <= wl;
		@(negedge clk);
		cfg_wr_en <= 0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_power();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// one vertex; occasionally a long in-band run of full bins to saturate the sum
	task automatic send_vertex(input int unsigned lo, input int unsigned hi);
		int nb;
		logic [5:0] idx;
		bit sat, lv;
		sat = ($urandom_range(0, 39) == 0) && (lo < hi);
		nb = sat ? 70 : $urandom_range(1, 6);
		lv = ($urandom_range(0, 3) == 0);
		for (int b = 0; b < nb; b++) begin
			if (sat) idx = 6'(lo);
			else if ($urandom_range(0, 2) == 0) idx = $urandom_range(0, 63);
			else if (lo < hi) idx = $urandom_range(lo, (hi > 64 ? 64 : hi) - 1);
			else idx = $urandom_range(0, 63);
			if (b == nb - 1) send_bin(sat ? 32'hFFFF_FFFF : rand_power(), idx, 1, lv);
			else send_bin(sat ? 32'hFFFF_FFFF : rand_power(), idx, 0,
				($urandom_range(0, 7) == 0));
		end
	endtask

	initial begin
		logic [6:0] lo_set [10] = '{0, 63, 10, 0, 20, 5, 8, 0, 30, 3};
		logic [6:0] hi_set [10] = '{64, 64, 5, 1, 40, 50, 12, 64, 33, 60};
		logic [6:0] wl_set [10] = '{2, 32, 5, 63, 0, 3, 32, 1, 8, 17};
		int phase;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_wr_en = 0;
		cfg_index = CFG_NONE;
		cfg_data = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 0;
		bins_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed, reset band 8..12
		send_bin(32'h0, 6'd0, 1, 0);
		send_bin(32'hFFFF_FFFF, 6'd8, 0, 0);
		send_bin(32'hFFFF_FFFF, 6'd11, 1, 1);
		send_bin(32'h0000_0100, 6'd9, 0, 1);
		send_bin(32'h0, 6'd63, 1, 0);
		send_bin(32'h0000_0001, 6'd12, 1, 0);
		send_bin(32'h8000_0000, 6'd10, 1, 1);
		send_bin(32'h0001_0000, 6'd8, 1, 0);
		send_bin(32'h0000_0000, 6'd7, 1, 0);
		send_bin(32'h5555_5555, 6'd11, 0, 0);
		send_bin(32'hAAAA_AAAA, 6'd11, 1, 1);
		send_bin(32'h0040_0000, 6'd9, 1, 0);
		send_bin(32'h0000_0200, 6'd9, 1, 1);
		drain();

		phase = 0;
		while (bins_sent < 1950) begin
			write_regs(lo_set[phase % 10], hi_set[phase % 10], wl_set[phase % 10]);
			case (phase % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 85; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 85; end
				default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
			endcase
			for (int v = 0; v < 55 && bins_sent < 1950; v++) begin
				if (phase == 2 && v == 20) hold_req = 500;
				if (phase == 5 && v == 25) begin
					in_valid <= 0;
					while (pending != 0) @(negedge clk);
				end
				send_vertex(lo_set[phase % 10], hi_set[phase % 10]);
			end
			drain();
			phase++;
		end

		if (fail_count == 0) $display("band_power_window_normalizer verification clean");
		else $display("band_power_window_normalizer verification failed");
		$finish;
	end
endmodule

// ===== band_power_window_normalizer.f =====
hdl/bpwn_pkg.sv
hdl/bpwn_div.sv
hdl/band_power_window_normalizer.sv
dv/bpwn_checker.sv
dv/band_power_window_normalizer_tb.sv
